// ===== design/newest_events_sorted_window_core_macros.svh =====
// ============================================================================
// Assertion macros for the newest events sorted window core
// Concurrent checks on clk, switched off in synthesis builds.
// ============================================================================
`ifndef NEWEST_EVENTS_SORTED_WINDOW_CORE_MACROS_SVH
`define NEWEST_EVENTS_SORTED_WINDOW_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, idle during reset
`define NESW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nesw check failed");

// Next-cycle implication, idle during reset
`define NESW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nesw check failed");

`else

`define NESW_ASSERT_NOW(label, ante, cons)
`define NESW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/nesw_pkg.sv =====
// ============================================================================
// nesw_pkg
// Shared widths, register indexes and cell control types.
// ============================================================================
package nesw_pkg;

    localparam int TICK_W      = 31;
    localparam int WORLD_W     = 8;
    localparam int TYPE_W      = 4;
    localparam int LIFE_W      = 16;
    localparam int PAY_PORT_W  = 32;
    localparam int COUNT_OUT_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd800;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WANTED_TYPE = 1'b0,
        REG_LIFETIME    = 1'b1
    } cfg_reg_t;

    // What the whole chain does this cycle
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_EVICT  = 2'd2,
        MODE_ROTATE = 2'd3
    } cell_mode_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        cell_mode_t mode;
        logic       occupied;
        logic       at_fill;
        logic       tail;
    } cell_ctrl_t;

endpackage

// ===== design/nesw_cell.sv =====
// ============================================================================
// nesw_cell
// One slot of the sorted chain: compares its tick and takes new data
// from the event, its left or right neighbour, or the head of the chain.
// ============================================================================
module nesw_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                            clk,
    input  nesw_pkg::cell_ctrl_t            ctrl,
    input  logic [nesw_pkg::TICK_W-1:0]     new_tick,
    input  logic [PAYLOAD_BITS-1:0]         new_payload,
    input  logic [nesw_pkg::TICK_W-1:0]     left_tick,
    input  logic [PAYLOAD_BITS-1:0]         left_payload,
    input  logic                            left_gt,
    input  logic [nesw_pkg::TICK_W-1:0]     right_tick,
    input  logic [PAYLOAD_BITS-1:0]         right_payload,
    input  logic                            right_le,
    input  logic [nesw_pkg::TICK_W-1:0]     wrap_tick,
    input  logic [PAYLOAD_BITS-1:0]         wrap_payload,
    output logic [nesw_pkg::TICK_W-1:0]     tick_out,
    output logic [PAYLOAD_BITS-1:0]         payload_out,
    output logic                            gt_out,
    output logic                            le_out
);

    logic [nesw_pkg::TICK_W-1:0] tick_reg;
    logic [nesw_pkg::TICK_W-1:0] tick_next;
    logic [PAYLOAD_BITS-1:0]     payload_reg;
    logic [PAYLOAD_BITS-1:0]     payload_next;
    logic                        newer_here;

    // Compare the stored tick against the incoming one
    assign newer_here = tick_reg > new_tick;
    assign gt_out     = ctrl.occupied && newer_here;
    assign le_out     = ctrl.occupied && !newer_here;

    // Pick the next content of the slot
    always_comb
    begin
        tick_next    = tick_reg;
        payload_next = payload_reg;
        unique case (ctrl.mode)
            nesw_pkg::MODE_INSERT:
            begin
                // shift right behind newer entries, drop the event into the gap
                if (left_gt)
                begin
                    tick_next    = left_tick;
                    payload_next = left_payload;
                end
                else if (gt_out || ctrl.at_fill)
                begin
                    tick_next    = new_tick;
                    payload_next = new_payload;
                end
            end
            nesw_pkg::MODE_EVICT:
            begin
                // oldest falls off the head, older-or-equal entries move down
                if (right_le)
                begin
                    tick_next    = right_tick;
                    payload_next = right_payload;
                end
                else if (!newer_here)
                begin
                    tick_next    = new_tick;
                    payload_next = new_payload;
                end
            end
            nesw_pkg::MODE_ROTATE:
            begin
                // advance towards the head, the tail takes the old head
                if (ctrl.tail)
                begin
                    tick_next    = wrap_tick;
                    payload_next = wrap_payload;
                end
                else if (ctrl.occupied)
                begin
                    tick_next    = right_tick;
                    payload_next = right_payload;
                end
            end
            default:
            begin
                tick_next    = tick_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    // Slot storage, written only through the chain
    always_ff @(posedge clk)
    begin
        tick_reg    <= tick_next;
        payload_reg <= payload_next;
    end

    assign tick_out    = tick_reg;
    assign payload_out = payload_reg;

endmodule

// ===== design/newest_events_sorted_window_core.sv =====
// ============================================================================
// newest_events_sorted_window_core
// Keeps the newest matching events of a scan in tick order and emits them.
// ============================================================================
// Input words arrive on in_valid/in_ready, one event per word. Matching events
// (world, decode status, wanted type, tick inside the lifetime window) go into
// a chain of CAPACITY slots kept in ascending tick order, equal ticks in
// arrival order. A full chain drops an event no newer than its oldest entry,
// otherwise evicts the oldest. start_scan empties the chain first.
// A word without end_scan leaves in_ready high; the next word may follow at once.
// A word with end_scan starts the emission: the chain rotates one slot a
// cycle towards its head and the head is copied to the output register;
// the first result word is loaded in ST_EMIT after acceptance, and the rest
// follow one a cycle, oldest first, max(1, count) words in all. in_ready is
// low until the last result is loaded; an empty window gives one word with
// entry_valid low. After a full rotation the chain is back in order, so the
// window is kept. A stalled out_ready holds the output register and halts
// the rotation. Configuration words on cfg_valid/cfg_ready are always taken.
// Reset empties the window, drops any pending result and sets wanted_type to
// 0 and lifetime_ticks to 800; slot contents need no clearing.
// ============================================================================
`include "newest_events_sorted_window_core_macros.svh"

module newest_events_sorted_window_core #(
    parameter int CAPACITY     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                start_scan,
    input  logic [nesw_pkg::TICK_W-1:0]         frame_tick,
    input  logic [nesw_pkg::WORLD_W-1:0]        frame_world,
    input  logic                                has_event,
    input  logic [nesw_pkg::TICK_W-1:0]         event_tick,
    input  logic [nesw_pkg::WORLD_W-1:0]        event_world,
    input  logic                                decoded_ok,
    input  logic [nesw_pkg::TYPE_W-1:0]         event_type,
    input  logic [nesw_pkg::PAY_PORT_W-1:0]     event_payload,
    input  logic                                end_scan,
    // result words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                entry_valid,
    output logic [nesw_pkg::TICK_W-1:0]         entry_tick,
    output logic [nesw_pkg::PAY_PORT_W-1:0]     entry_payload,
    output logic [nesw_pkg::COUNT_OUT_W-1:0]    kept_count,
    output logic                                last_of_run,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nesw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nesw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [CW-1:0]                       fill_reg;
    logic [CW-1:0]                       fill_next;
    logic [CW-1:0]                       rem_reg;
    logic [CW-1:0]                       rem_next;
    logic [nesw_pkg::TYPE_W-1:0]         wanted_type_reg;
    logic [nesw_pkg::LIFE_W-1:0]         lifetime_reg;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                entry_valid_reg;
    logic [nesw_pkg::TICK_W-1:0]         entry_tick_reg;
    logic [nesw_pkg::PAY_PORT_W-1:0]     entry_payload_reg;
    logic [nesw_pkg::COUNT_OUT_W-1:0]    kept_count_reg;
    logic                                last_of_run_reg;

    logic                                in_fire;
    logic                                emit_load;
    logic                                event_kept;
    logic [nesw_pkg::TICK_W-1:0]         tick_age;
    logic [CW-1:0]                       eff_fill;
    logic [CW-1:0]                       occ_count;
    logic [CW-1:0]                       tail_idx;
    logic                                chain_full;
    nesw_pkg::cell_mode_t                chain_mode;
    logic [PAYLOAD_BITS+31:0]            pay_in_wide;
    logic [PAYLOAD_BITS-1:0]             new_payload;
    logic [PAYLOAD_BITS+31:0]            pay_out_wide;
    logic [CW+3:0]                       fill_wide;

    nesw_pkg::cell_ctrl_t                cell_ctrl    [CAPACITY];
    logic [nesw_pkg::TICK_W-1:0]         cell_tick    [CAPACITY];
    logic [PAYLOAD_BITS-1:0]             cell_payload [CAPACITY];
    logic                                cell_gt      [CAPACITY];
    logic                                cell_le      [CAPACITY];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    // Filter the event against the scan and the window
    assign tick_age   = frame_tick - event_tick;
    assign event_kept = has_event && decoded_ok
                        && (event_world == frame_world)
                        && (event_type == wanted_type_reg)
                        && (event_tick <= frame_tick)
                        && (tick_age < nesw_pkg::TICK_W'(lifetime_reg));

    // Resize the payload to the slot width
    assign pay_in_wide  = (PAYLOAD_BITS + 32)'(event_payload);
    assign new_payload  = pay_in_wide[PAYLOAD_BITS-1:0];
    assign pay_out_wide = (PAYLOAD_BITS + 32)'(cell_payload[0]);

    // Count seen by this word, after an optional clear
    assign eff_fill   = start_scan ? '0 : fill_reg;
    assign chain_full = (eff_fill == CW'(CAPACITY));
    assign occ_count  = (state_reg == ST_IDLE) ? eff_fill : fill_reg;
    assign tail_idx   = fill_reg - CW'(1);

    // Choose the chain operation
    always_comb
    begin
        chain_mode = nesw_pkg::MODE_HOLD;
        fill_next  = fill_reg;
        if (in_fire)
        begin
            fill_next = eff_fill;
            if (event_kept)
            begin
                if (!chain_full)
                begin
                    chain_mode = nesw_pkg::MODE_INSERT;
                    fill_next  = eff_fill + CW'(1);
                end
                else if (cell_tick[0] < event_tick)
                begin
                    chain_mode = nesw_pkg::MODE_EVICT;
                end
            end
        end
        else if (emit_load)
        begin
            chain_mode = nesw_pkg::MODE_ROTATE;
        end
    end

    // Per-slot control
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].mode     = chain_mode;
            cell_ctrl[i].occupied = CW'(i) < occ_count;
            cell_ctrl[i].at_fill  = CW'(i) == eff_fill;
            cell_ctrl[i].tail     = CW'(i) == tail_idx;
        end
    end

    // Build the chain of slots
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [nesw_pkg::TICK_W-1:0] l_tick;
        logic [PAYLOAD_BITS-1:0]     l_payload;
        logic                        l_gt;
        logic [nesw_pkg::TICK_W-1:0] r_tick;
        logic [PAYLOAD_BITS-1:0]     r_payload;
        logic                        r_le;

        if (g == 0)
        begin : g_head
            assign l_tick    = '0;
            assign l_payload = '0;
            assign l_gt      = 1'b0;
        end
        else
        begin : g_body
            assign l_tick    = cell_tick[g-1];
            assign l_payload = cell_payload[g-1];
            assign l_gt      = cell_gt[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign r_tick    = '0;
            assign r_payload = '0;
            assign r_le      = 1'b0;
        end
        else
        begin : g_mid
            assign r_tick    = cell_tick[g+1];
            assign r_payload = cell_payload[g+1];
            assign r_le      = cell_le[g+1];
        end

        nesw_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk           (clk),
            .ctrl          (cell_ctrl[g]),
            .new_tick      (event_tick),
            .new_payload   (new_payload),
            .left_tick     (l_tick),
            .left_payload  (l_payload),
            .left_gt       (l_gt),
            .right_tick    (r_tick),
            .right_payload (r_payload),
            .right_le      (r_le),
            .wrap_tick     (cell_tick[0]),
            .wrap_payload  (cell_payload[0]),
            .tick_out      (cell_tick[g]),
            .payload_out   (cell_payload[g]),
            .gt_out        (cell_gt[g]),
            .le_out        (cell_le[g])
        );
    end

    // Sequence the emission
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && end_scan)
                begin
                    state_next = ST_EMIT;
                    rem_next   = fill_next;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    rem_next       = rem_reg - CW'(1);
                    if (rem_reg <= CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg <= '0;
            lifetime_reg    <= nesw_pkg::LIFETIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (nesw_pkg::cfg_reg_t'(cfg_index))
                nesw_pkg::REG_WANTED_TYPE: wanted_type_reg <= cfg_data[nesw_pkg::TYPE_W-1:0];
                nesw_pkg::REG_LIFETIME:    lifetime_reg    <= cfg_data;
                default:                   lifetime_reg    <= lifetime_reg;
            endcase
        end
    end

    assign fill_wide = (CW + 4)'(fill_reg);

    // Load the head of the chain into the output word
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            entry_valid_reg   <= (fill_reg != '0);
            entry_tick_reg    <= (fill_reg != '0) ? cell_tick[0] : '0;
            entry_payload_reg <= (fill_reg != '0) ? pay_out_wide[31:0] : '0;
            kept_count_reg    <= fill_wide[3:0];
            last_of_run_reg   <= (rem_reg <= CW'(1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_valid   = entry_valid_reg;
    assign entry_tick    = entry_tick_reg;
    assign entry_payload = entry_payload_reg;
    assign kept_count    = kept_count_reg;
    assign last_of_run   = last_of_run_reg;

    // Checks
    `NESW_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(CAPACITY))
    `NESW_ASSERT_NOW(a_empty_word, out_valid && !entry_valid, last_of_run && kept_count == '0)
    `NESW_ASSERT_NEXT(a_insert_grows, in_fire && !start_scan && event_kept && !chain_full, fill_reg == $past(fill_reg) + CW'(1))

endmodule
